// ----- hdl/pfr_pkg.sv -----
package pfr_pkg;

    // table and buffer sizes
    localparam int MAX_RULES     = 16;
    localparam int BUF_BYTES     = 2048;
    localparam int MAX_RULE_SIZE = 8;

    // field widths
    localparam int OFF_W  = 12;
    localparam int SIZE_W = 4;
    localparam int VAL_W  = 64;
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // derived widths
    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int POS_W = $clog2(BUF_BYTES + 1);
    localparam int CMP_W = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;
    localparam int SEL_W = $clog2(MAX_RULE_SIZE);

    // stream packing
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_SIZE  = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // one word as it travels down the chain of cells
    typedef struct packed {
        logic                vld;
        logic                kind;
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [POS_W-1:0]    pos;
        logic [CNT_W-1:0]    cnt;
        t_status             status;
        logic                wr;
        logic [CNT_W-1:0]    idx;
        logic [OFF_W-1:0]    offset;
        logic [SIZE_W-1:0]   size;
        logic [VAL_W-1:0]    value;
    } t_item;

endpackage

// ----- hdl/pfr_head.sv -----
module pfr_head (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  pfr_pkg::t_cmd                i_cmd,
    input  logic [pfr_pkg::BYTE_W-1:0]   i_data,
    input  logic                         i_last,
    input  logic [pfr_pkg::OFF_W-1:0]    i_offset,
    input  logic [pfr_pkg::SIZE_W-1:0]   i_size,
    input  logic [pfr_pkg::VAL_W-1:0]    i_value,
    output pfr_pkg::t_item               o_item
);

    logic [pfr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [pfr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [pfr_pkg::CMP_W-1:0] end_pos;

    assign end_pos = pfr_pkg::CMP_W'(i_offset) + pfr_pkg::CMP_W'(i_size);

    // decode the command, check adds and advance position and rule count
    always_comb begin
        n_pos         = r_pos;
        n_cnt         = r_cnt;
        o_item        = '0;
        o_item.data   = i_data;
        o_item.last   = i_last;
        o_item.pos    = r_pos;
        o_item.cnt    = r_cnt;
        o_item.idx    = r_cnt;
        o_item.offset = i_offset;
        o_item.size   = i_size;
        o_item.value  = i_value;
        o_item.status = pfr_pkg::ST_OK;
        unique case (i_cmd)
            pfr_pkg::CMD_BYTE: begin
                o_item.vld  = 1'b1;
                o_item.kind = pfr_pkg::KIND_BYTE;
                if (i_last) begin
                    n_pos = '0;
                end else if (r_pos < pfr_pkg::POS_W'(pfr_pkg::BUF_BYTES)) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            pfr_pkg::CMD_ADD: begin
                o_item.vld  = 1'b1;
                o_item.kind = pfr_pkg::KIND_STATUS;
                o_item.data = '0;
                o_item.last = 1'b0;
                if (r_cnt >= pfr_pkg::CNT_W'(pfr_pkg::MAX_RULES)) begin
                    o_item.status = pfr_pkg::ST_FULL;
                end else if (i_size == '0 ||
                             i_size > pfr_pkg::SIZE_W'(pfr_pkg::MAX_RULE_SIZE)) begin
                    o_item.status = pfr_pkg::ST_BAD_SIZE;
                end else if (end_pos > pfr_pkg::CMP_W'(pfr_pkg::BUF_BYTES)) begin
                    o_item.status = pfr_pkg::ST_TOO_LARGE;
                end else begin
                    o_item.wr = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            pfr_pkg::CMD_CLEAR: begin
                o_item.vld  = 1'b1;
                o_item.kind = pfr_pkg::KIND_STATUS;
                o_item.data = '0;
                o_item.last = 1'b0;
                n_cnt       = '0;
            end
            default: begin
                o_item.vld = 1'b0;
            end
        endcase
    end

    // position and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cnt <= '0;
        end else if (i_acc) begin
            r_pos <= n_pos;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hdl/pfr_cell.sv -----
module pfr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [pfr_pkg::CNT_W-1:0]   i_cell_idx,
    input  pfr_pkg::t_item              i_item,
    output pfr_pkg::t_item              o_item
);

    // rule held by this cell
    logic [pfr_pkg::OFF_W-1:0]  r_off;
    logic [pfr_pkg::SIZE_W-1:0] r_size;
    logic [pfr_pkg::VAL_W-1:0]  r_val;

    pfr_pkg::t_item             r_item, n_item;
    logic                       r_vld;

    logic [pfr_pkg::CMP_W-1:0]  pos_x, off_x, end_x, diff;
    logic [pfr_pkg::SIZE_W-1:0] sel_full;
    logic [pfr_pkg::SEL_W-1:0]  sel;
    logic                       hit;

    // range check of the word position against this rule
    always_comb begin
        pos_x    = pfr_pkg::CMP_W'(i_item.pos);
        off_x    = pfr_pkg::CMP_W'(r_off);
        end_x    = off_x + pfr_pkg::CMP_W'(r_size);
        diff     = pos_x - off_x;
        sel_full = r_size - 1'b1 - pfr_pkg::SIZE_W'(diff);
        sel      = sel_full[pfr_pkg::SEL_W-1:0];
        hit      = (i_item.kind == pfr_pkg::KIND_BYTE) && (i_cell_idx < i_item.cnt) &&
                   (pos_x >= off_x) && (pos_x < end_x);
    end

    // rewrite the byte, later cells override earlier ones
    always_comb begin
        n_item = i_item;
        if (hit) begin
            n_item.data = r_val[sel*pfr_pkg::BYTE_W +: pfr_pkg::BYTE_W];
        end
    end

    // capture a new rule addressed to this cell
    always_ff @(posedge i_clk) begin
        if (i_adv && i_item.vld && i_item.wr && i_item.idx == i_cell_idx) begin
            r_off  <= i_item.offset;
            r_size <= i_item.size;
            r_val  <= i_item.value;
        end
    end

    // pass the word on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    always_comb begin
        o_item     = r_item;
        o_item.vld = r_vld;
    end

endmodule

// ----- hdl/packet_field_rewriter_unit.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata, tuser = cmd, tlast = last_byte
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata, tuser = result_kind, tlast = out_last
//
// one word accepted per cycle, back to back, unless the chain is held; each word
// passes through the chain of rule cells, one cell per table entry, each registered.
// reset clears the rule count, the byte position and all word valid bits.
// the whole chain holds while the last cell has a word the sink does not take.
// a word with the unused command is accepted and gives no result.
module packet_field_rewriter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // data_byte[7:0], rule_offset[19:8], rule_size[23:20], rule_value[87:24]
    input  logic [pfr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd[1:0]
    input  logic [pfr_pkg::CMD_W-1:0]         s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_byte[7:0], status[9:8], zero[15:10]
    output logic [pfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // result_kind[0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    pfr_pkg::t_item chain [pfr_pkg::MAX_RULES+1];
    logic           adv;
    logic           acc;

    // global advance of the chain
    assign adv           = !chain[pfr_pkg::MAX_RULES].vld || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;

    // entry: decode, status checks, position and count
    pfr_head u_head (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_cmd    (pfr_pkg::t_cmd'(s_axis_tuser)),
        .i_data   (s_axis_tdata[7:0]),
        .i_last   (s_axis_tlast),
        .i_offset (s_axis_tdata[19:8]),
        .i_size   (s_axis_tdata[23:20]),
        .i_value  (s_axis_tdata[87:24]),
        .o_item   (chain[0])
    );

    // gate the entry word with the input handshake
    pfr_pkg::t_item entry;
    always_comb begin
        entry     = chain[0];
        entry.vld = chain[0].vld && s_axis_tvalid;
    end

    // chain of rule cells
    for (genvar k = 0; k < pfr_pkg::MAX_RULES; k++) begin : g_cell
        pfr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_cell_idx (pfr_pkg::CNT_W'(k)),
            .i_item     ((k == 0) ? entry : chain[k]),
            .o_item     (chain[k+1])
        );
    end

    // result word from the last cell register
    assign m_axis_tvalid = chain[pfr_pkg::MAX_RULES].vld;
    assign m_axis_tuser  = chain[pfr_pkg::MAX_RULES].kind;
    assign m_axis_tlast  = chain[pfr_pkg::MAX_RULES].last;
    assign m_axis_tdata  = {6'b0, chain[pfr_pkg::MAX_RULES].status,
                            chain[pfr_pkg::MAX_RULES].data};

endmodule
